FILE: rtl/core/tpp_pkg.sv
package tpp_pkg;

    // Conversion modes, as written to the mode register.
    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_ALPHA_EXP = 3'd1;
    localparam logic [2:0] MODE_NORMAL    = 3'd2;
    localparam logic [2:0] MODE_SWAP_RA   = 3'd3;
    localparam logic [2:0] MODE_YCOCG     = 3'd4;
    localparam logic [2:0] MODE_SWAP_LA   = 3'd5;
    localparam logic [2:0] MODE_SWAP_RG   = 3'd6;

    // Register indexes on the configuration port.
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_XSEL = 1'b1;

    // Radius squared of the unit sphere in 8-bit units (255 * 255).
    localparam logic [16:0] RAD_SQ = 17'd65025;

    // Number of root cells: one root bit per cell.
    localparam int ROOT_CELLS = 8;

    // Stages: prep, reduce, root cells, pack.
    localparam int NUM_STAGES = ROOT_CELLS + 3;

    // Word carried down the pipeline; fields fill in as it goes.
    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  nx;
        logic [15:0] sq_u;
        logic [15:0] sq_v;
        logic [15:0] prod0;
        logic [15:0] prod1;
        logic [15:0] prod2;
        logic [7:0]  q0;
        logic [7:0]  q1;
        logic [7:0]  q2;
        logic        dpos;
        logic [15:0] rad;
        logic [9:0]  rem;
        logic [7:0]  root;
    } t_word;

    // Divide a product of two bytes by 255, truncated.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [7:0] est;
        logic [8:0] r;
        est = p[15:8];
        r   = {1'b0, p[7:0]} + {1'b0, est};
        return (r >= 9'd255) ? est + 8'd1 : est;
    endfunction

    // Clip a signed sum to the byte range.
    function automatic logic [7:0] clip_u8(input logic signed [10:0] v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/texture_pixel_postprocessor.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_byte0 .. i_byte3
// output    o_out_valid / i_out_stall  o_out0 .. o_out3
// config    APB write/read             mode at 0x0, x_from_alpha at 0x4
//
// One word is taken per cycle while o_in_stall is low.
// Each result passes through the multiply and reduce stages, the eight root
// cells, one root bit each, and the output stage.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with mode 0 and x_from_alpha 1.
// A stall at the output holds the pipeline only once the stages ahead of
// it are full; bubbles close up while it waits.
module texture_pixel_postprocessor
    import tpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte0,
    input  logic [7:0]  i_byte1,
    input  logic [7:0]  i_byte2,
    input  logic [7:0]  i_byte3,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out0,
    output logic [7:0]  o_out1,
    output logic [7:0]  o_out2,
    output logic [7:0]  o_out3,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0]            r_mode;
    logic                  r_xsel;
    logic [NUM_STAGES-1:0] vld;
    logic [NUM_STAGES:0]   en;
    t_word                 stage_word [NUM_STAGES-1];

    // Configuration registers; the index is the word address bit.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_xsel <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MODE: r_mode <= pwdata[2:0];
                REG_XSEL: r_xsel <= pwdata[0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE: prdata = {29'd0, r_mode};
            REG_XSEL: prdata = {31'd0, r_xsel};
            default:  prdata = 32'd0;
        endcase
    end

    // A stage moves when it is empty or the stage after it moves.
    assign en[NUM_STAGES] = !i_out_stall;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
        assign en[k] = !vld[k] || en[k+1];
    end

    assign o_in_stall = !en[0];

    // Squares and products.
    tpp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[0]),
        .i_valid (i_in_valid),
        .i_mode  (r_mode),
        .i_xsel  (r_xsel),
        .i_b0    (i_byte0),
        .i_b1    (i_byte1),
        .i_b2    (i_byte2),
        .i_b3    (i_byte3),
        .o_valid (vld[0]),
        .o_word  (stage_word[0])
    );

    // Radicand and divisions by 255.
    tpp_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[1]),
        .i_valid (vld[0]),
        .i_word  (stage_word[0]),
        .o_valid (vld[1]),
        .o_word  (stage_word[1])
    );

    // Chain of root cells, most significant root bit first.
    for (genvar c = 0; c < ROOT_CELLS; c++) begin : g_cell
        tpp_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[c+2]),
            .i_valid (vld[c+1]),
            .i_word  (stage_word[c+1]),
            .o_valid (vld[c+2]),
            .o_word  (stage_word[c+2])
        );
    end

    // Output selection and output register.
    tpp_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[NUM_STAGES-1]),
        .i_valid (vld[NUM_STAGES-2]),
        .i_word  (stage_word[NUM_STAGES-2]),
        .o_valid (vld[NUM_STAGES-1]),
        .o_out0  (o_out0),
        .o_out1  (o_out1),
        .o_out2  (o_out2),
        .o_out3  (o_out3)
    );

    assign o_out_valid = vld[NUM_STAGES-1];

`ifndef NO_ASSERTIONS
    // The input is held off only when every stage holds a word.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&vld))
        else $error("input stalled with an empty stage");

    // A full pipeline facing a stalled output must hold off the input.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&vld) && i_out_stall) |-> o_in_stall)
        else $error("input taken while the pipeline is blocked");

    // An accepted word lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> vld[0])
        else $error("accepted word lost at the first stage");
`endif

endmodule

FILE: rtl/core/tpp_prep.sv
module tpp_prep
    import tpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  logic [2:0] i_mode,
    input  logic       i_xsel,
    input  logic [7:0] i_b0,
    input  logic [7:0] i_b1,
    input  logic [7:0] i_b2,
    input  logic [7:0] i_b3,
    output logic       o_valid,
    output t_word      o_word
);

    logic       r_valid;
    t_word      r_word;
    t_word      n_word;
    logic [7:0] xv;
    logic [7:0] abs_u;
    logic [7:0] abs_v;

    // |2x-255| is always odd, so it is built from the low seven bits.
    always_comb begin
        xv    = i_xsel ? i_b3 : i_b0;
        abs_u = xv[7] ? {xv[6:0], 1'b1} : {~xv[6:0], 1'b1};
        abs_v = i_b1[7] ? {i_b1[6:0], 1'b1} : {~i_b1[6:0], 1'b1};
    end

    // Squares for the normal map and products for the alpha exponent.
    always_comb begin
        n_word       = '0;
        n_word.mode  = i_mode;
        n_word.b0    = i_b0;
        n_word.b1    = i_b1;
        n_word.b2    = i_b2;
        n_word.b3    = i_b3;
        n_word.nx    = xv;
        n_word.sq_u  = {8'd0, abs_u} * {8'd0, abs_u};
        n_word.sq_v  = {8'd0, abs_v} * {8'd0, abs_v};
        n_word.prod0 = {8'd0, i_b0} * {8'd0, i_b3};
        n_word.prod1 = {8'd0, i_b1} * {8'd0, i_b3};
        n_word.prod2 = {8'd0, i_b2} * {8'd0, i_b3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: rtl/core/tpp_reduce.sv
module tpp_reduce
    import tpp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    logic        r_valid;
    t_word       r_word;
    t_word       n_word;
    logic [16:0] sum_sq;
    logic [16:0] diff;

    // Radicand of the Z term, and the three divisions by 255.
    always_comb begin
        sum_sq       = {1'b0, i_word.sq_u} + {1'b0, i_word.sq_v};
        diff         = RAD_SQ - sum_sq;
        n_word       = i_word;
        n_word.dpos  = (sum_sq < RAD_SQ);
        n_word.rad   = n_word.dpos ? diff[15:0] : 16'd0;
        n_word.rem   = '0;
        n_word.root  = '0;
        n_word.q0    = div255(i_word.prod0);
        n_word.q1    = div255(i_word.prod1);
        n_word.q2    = div255(i_word.prod2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: rtl/core/tpp_root_cell.sv
module tpp_root_cell
    import tpp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_word i_word,
    output logic  o_valid,
    output t_word o_word
);

    logic        r_valid;
    t_word       r_word;
    t_word       n_word;
    logic [11:0] acc;
    logic [11:0] trial;

    // One root bit: bring down the next two radicand bits and try 4q+1.
    always_comb begin
        acc    = {i_word.rem, i_word.rad[15:14]};
        trial  = {2'b00, i_word.root, 2'b01};
        n_word = i_word;
        n_word.rad = {i_word.rad[13:0], 2'b00};
        if (acc >= trial) begin
            n_word.rem  = 10'(acc - trial);
            n_word.root = {i_word.root[6:0], 1'b1};
        end else begin
            n_word.rem  = acc[9:0];
            n_word.root = {i_word.root[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: rtl/core/tpp_pack.sv
module tpp_pack
    import tpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_word      i_word,
    output logic       o_valid,
    output logic [7:0] o_out0,
    output logic [7:0] o_out1,
    output logic [7:0] o_out2,
    output logic [7:0] o_out3
);

    logic              r_valid;
    logic [7:0]        r_out0;
    logic [7:0]        r_out1;
    logic [7:0]        r_out2;
    logic [7:0]        r_out3;
    logic [7:0]        n_out0;
    logic [7:0]        n_out1;
    logic [7:0]        n_out2;
    logic [7:0]        n_out3;
    logic [8:0]        z_sum;
    logic [7:0]        z;
    logic signed [10:0] ys;
    logic signed [10:0] cgs;
    logic signed [10:0] cos;

    // Z of the normal map, 127 when the point lies outside the sphere.
    always_comb begin
        z_sum = 9'd255 + {1'b0, i_word.root};
        z     = i_word.dpos ? z_sum[8:1] : 8'd127;
        ys    = signed'({3'b000, i_word.b3});
        cgs   = signed'({3'b000, i_word.b1}) - 11'sd128;
        cos   = signed'({3'b000, i_word.b2}) - 11'sd128;
    end

    // Select the output bytes for the word's mode.
    always_comb begin
        n_out0 = i_word.b0;
        n_out1 = i_word.b1;
        n_out2 = i_word.b2;
        n_out3 = i_word.b3;
        case (i_word.mode)
            MODE_ALPHA_EXP: begin
                n_out0 = i_word.q0;
                n_out1 = i_word.q1;
                n_out2 = i_word.q2;
                n_out3 = 8'd255;
            end
            MODE_NORMAL: begin
                n_out0 = i_word.nx;
                n_out2 = z;
                n_out3 = 8'd255;
            end
            MODE_SWAP_RA: begin
                n_out0 = i_word.b3;
                n_out3 = i_word.b0;
            end
            MODE_YCOCG: begin
                n_out0 = clip_u8(ys + cos - cgs);
                n_out1 = clip_u8(ys + cgs);
                n_out2 = clip_u8(ys - cos - cgs);
                n_out3 = i_word.b0;
            end
            MODE_SWAP_LA: begin
                n_out0 = i_word.b1;
                n_out1 = i_word.b0;
                n_out2 = i_word.b3;
                n_out3 = i_word.b2;
            end
            MODE_SWAP_RG: begin
                n_out0 = i_word.b1;
                n_out1 = i_word.b0;
            end
            default: begin
                n_out0 = i_word.b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out0 <= n_out0;
            r_out1 <= n_out1;
            r_out2 <= n_out2;
            r_out3 <= n_out3;
        end
    end

    assign o_valid = r_valid;
    assign o_out0  = r_out0;
    assign o_out1  = r_out1;
    assign o_out2  = r_out2;
    assign o_out3  = r_out3;

endmodule

FILE: test/texture_pixel_postprocessor_tb.sv
module texture_pixel_postprocessor_tb;
    import tpp_pkg::*;

    localparam int LATENCY     = NUM_STAGES;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;
    // Mode 7 is not assigned and must behave as pass-through.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
    } pixel_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        px_valid = 1'b0;
    logic        px_stall;
    pixel_t      px_word  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    pixel_t      res_word;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the configuration registers.
    logic [2:0]  cfg_mode = MODE_NONE;
    logic        cfg_xsel = 1'b1;

    pixel_t      pixel_q[$];
    pixel_t      converted_q[$];
    int          words_queued  = 0;
    int          words_checked = 0;
    int          fail_cnt      = 0;

    // Idling controls, changed only between phases.
    int          gap_max   = 0;
    int          burst_max = 8;
    int          stall_max = 0;

    // Configuration plan after the reset-value phase.
    logic [2:0]  plan_mode[8] = '{MODE_ALPHA_EXP, MODE_NORMAL, MODE_NORMAL, MODE_SWAP_RA,
                                  MODE_YCOCG, MODE_SWAP_LA, MODE_SWAP_RG, MODE_UNUSED};
    logic        plan_xsel[8] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    texture_pixel_postprocessor u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (px_valid),
        .o_in_stall  (px_stall),
        .i_byte0     (px_word.c0),
        .i_byte1     (px_word.c1),
        .i_byte2     (px_word.c2),
        .i_byte3     (px_word.c3),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out0      (res_word.c0),
        .o_out1      (res_word.c1),
        .o_out2      (res_word.c2),
        .o_out3      (res_word.c3),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor of the square root, one bit at a time from the top.
    function automatic logic [7:0] root_floor(input int d);
        logic [7:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            r[i] = 1'b1;
            if (int'(r) * int'(r) > d) begin
                r[i] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_byte(input int v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return 8'(v);
    endfunction

    // Expected converted word for one input word under the given settings.
    function automatic pixel_t convert_pixel(input pixel_t px, input logic [2:0] m,
                                             input logic xsel);
        pixel_t     q;
        logic [7:0] x;
        int         u;
        int         v;
        int         d;
        int         cg;
        int         co;
        int         luma;
        q = px;
        case (m)
            MODE_ALPHA_EXP: begin
                q.c0 = 8'(int'(px.c0) * int'(px.c3) / 255);
                q.c1 = 8'(int'(px.c1) * int'(px.c3) / 255);
                q.c2 = 8'(int'(px.c2) * int'(px.c3) / 255);
                q.c3 = 8'd255;
            end
            MODE_NORMAL: begin
                x = xsel ? px.c3 : px.c0;
                u = 2 * int'(x) - 255;
                v = 2 * int'(px.c1) - 255;
                d = int'(RAD_SQ) - u * u - v * v;
                q.c0 = x;
                q.c1 = px.c1;
                q.c2 = (d > 0) ? 8'((255 + int'(root_floor(d))) / 2) : 8'd127;
                q.c3 = 8'd255;
            end
            MODE_SWAP_RA: begin
                q.c0 = px.c3;
                q.c3 = px.c0;
            end
            MODE_YCOCG: begin
                cg   = int'(px.c1) - 128;
                co   = int'(px.c2) - 128;
                luma = int'(px.c3);
                q.c0 = clamp_byte(luma + co - cg);
                q.c1 = clamp_byte(luma + cg);
                q.c2 = clamp_byte(luma - co - cg);
                q.c3 = px.c0;
            end
            MODE_SWAP_LA: begin
                q.c0 = px.c1;
                q.c1 = px.c0;
                q.c2 = px.c3;
                q.c3 = px.c2;
            end
            MODE_SWAP_RG: begin
                q.c0 = px.c1;
                q.c1 = px.c0;
            end
            default: begin
            end
        endcase
        return q;
    endfunction

    task automatic note_failure(input string what);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endtask

    // Sender: words leave the pending queue in bursts separated by gaps.
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge clk) begin
        if (!rst_n) begin
            px_valid <= 1'b0;
        end else begin
            if (px_valid && !px_stall) begin
                converted_q.push_back(convert_pixel(px_word, cfg_mode, cfg_xsel));
            end
            if (px_valid && px_stall) begin
                // A stalled word stays on the port unchanged.
            end else if (gap_left > 0) begin
                gap_left--;
                px_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                px_word  <= pixel_q.pop_front();
                px_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, burst_max);
                    gap_left   = $urandom_range(0, gap_max);
                end
            end else begin
                px_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted word and stalls in runs of its own.
    int stall_left = 0;
    int flow_left  = 0;
    always @(posedge clk) begin
        pixel_t want;
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else begin
            if (res_valid && !res_stall) begin
                if (converted_q.size() == 0) begin
                    note_failure($sformatf("unexpected word %h", res_word));
                end else begin
                    want = converted_q.pop_front();
                    words_checked++;
                    if (res_word.c0 !== want.c0 || res_word.c1 !== want.c1 ||
                        res_word.c2 !== want.c2 || res_word.c3 !== want.c3) begin
                        note_failure($sformatf(
                            "mismatch: expected %h %h %h %h, got %h %h %h %h",
                            want.c0, want.c1, want.c2, want.c3,
                            res_word.c0, res_word.c1, res_word.c2, res_word.c3));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_stall <= 1'b1;
            end else if (flow_left > 0) begin
                flow_left--;
                res_stall <= 1'b0;
            end else begin
                stall_left = $urandom_range(0, stall_max);
                flow_left  = $urandom_range(1, 16);
                res_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    int idle_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || (px_valid && !px_stall) || (res_valid && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] m, input logic xsel);
        reg_write(REG_MODE, 32'(m));
        cfg_mode = m;
        reg_write(REG_XSEL, 32'(xsel));
        cfg_xsel = xsel;
    endtask

    // Each phase gets its own idling style, including none at all.
    task automatic pick_idling();
        case ($urandom_range(0, 3))
            0: begin gap_max = 0;  stall_max = 0; end
            1: begin gap_max = 10; stall_max = 0; end
            2: begin gap_max = 0;  stall_max = 8; end
            default: begin gap_max = 10; stall_max = 8; end
        endcase
        burst_max = $urandom_range(0, 12);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge clk);
        end while (words_checked != words_queued);
    endtask

    task automatic queue_word(input pixel_t p);
        pixel_q.push_back(p);
        words_queued++;
    endtask

    // Random bytes, leaning now and then toward the extremes.
    function automatic logic [7:0] random_byte();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom);
    endfunction

    task automatic fill_words(input bit with_directed, input int count);
        pixel_t p;
        if (with_directed) begin
            queue_word('{8'h00, 8'h00, 8'h00, 8'h00});
            queue_word('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
            if (cfg_mode == MODE_NORMAL) begin
                // Center of the disk, then just outside its rim.
                queue_word('{8'd127, 8'd128, 8'd0, 8'd127});
                queue_word('{8'd255, 8'd128, 8'd0, 8'd255});
            end
        end
        for (int n = 0; n < count; n++) begin
            p.c0 = random_byte();
            p.c1 = random_byte();
            p.c2 = random_byte();
            p.c3 = random_byte();
            queue_word(p);
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Registers still hold their reset values here.
        pick_idling();
        fill_words(1'b1, 60);

        foreach (plan_mode[k]) begin
            wait_drained();
            set_config(plan_mode[k], plan_xsel[k]);
            pick_idling();
            fill_words(1'b1, 70);
        end

        for (int k = 0; k < 5; k++) begin
            wait_drained();
            set_config(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            pick_idling();
            fill_words(1'b0, 70);
        end

        wait_drained();
        repeat (2 * LATENCY) @(posedge clk);
        if (converted_q.size() != 0) begin
            note_failure($sformatf("%0d words never arrived", converted_q.size()));
        end
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
